/* src/pst_pkg.sv */
// shared types, token codes and keyword tables for the pascal subset tokenizer
// no dependencies
package pst_pkg;

    localparam int NKW = 17;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } pst_in_t;

    typedef struct packed {
        logic        rec_kind;
        logic [7:0]  text_char;
        logic [5:0]  token_type;
        logic [15:0] token_line;
        logic [1:0]  error_code;
        logic        last;
    } pst_rec_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_COMMENT,
        M_COLON,
        M_LESS,
        M_GREATER
    } pst_mode_t;

    localparam logic       REC_CHAR = 1'b0;
    localparam logic       REC_END  = 1'b1;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_STRING  = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;

    localparam logic [5:0] T_IDENT   = 6'd16;
    localparam logic [5:0] T_STRLIT  = 6'd17;
    localparam logic [5:0] T_INTLIT  = 6'd18;
    localparam logic [5:0] T_ASSIGN  = 6'd19;
    localparam logic [5:0] T_NE      = 6'd20;
    localparam logic [5:0] T_LE      = 6'd21;
    localparam logic [5:0] T_GE      = 6'd22;
    localparam logic [5:0] T_PLUS    = 6'd23;
    localparam logic [5:0] T_MINUS   = 6'd24;
    localparam logic [5:0] T_STAR    = 6'd25;
    localparam logic [5:0] T_SLASH   = 6'd26;
    localparam logic [5:0] T_EQ      = 6'd27;
    localparam logic [5:0] T_LT      = 6'd28;
    localparam logic [5:0] T_GT      = 6'd29;
    localparam logic [5:0] T_LPAREN  = 6'd30;
    localparam logic [5:0] T_RPAREN  = 6'd31;
    localparam logic [5:0] T_COLON   = 6'd32;
    localparam logic [5:0] T_SEMI    = 6'd33;
    localparam logic [5:0] T_COMMA   = 6'd34;
    localparam logic [5:0] T_END     = 6'd35;

    // keyword spellings, left aligned, zero padded
    localparam logic [63:0] KW_TEXT [NKW] = '{
        {"program", 8'h00}, {"var", 40'h0}, {"begin", 24'h0}, {"end", 40'h0},
        {"integer", 8'h00}, {"boolean", 8'h00}, {"string", 16'h0}, {"true", 32'h0},
        {"false", 24'h0}, {"div", 40'h0}, {"mod", 40'h0}, {"and", 40'h0},
        {"or", 48'h0}, {"xor", 40'h0}, {"not", 40'h0}, {"writeln", 8'h00},
        {"readln", 16'h0}
    };
    localparam logic [2:0] KW_LEN [NKW] = '{
        3'd7, 3'd3, 3'd5, 3'd3, 3'd7, 3'd7, 3'd6, 3'd4, 3'd5, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd3, 3'd3, 3'd7, 3'd6
    };
    localparam logic [5:0] KW_TYPE [NKW] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd7, 6'd8, 6'd9, 6'd10,
        6'd11, 6'd12, 6'd13, 6'd14, 6'd15
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // drop candidates whose spelling differs at this position
    function automatic logic [NKW-1:0] kw_update(input logic [NKW-1:0] kwc,
                                                  input logic [2:0] pos,
                                                  input logic pos_ok,
                                                  input logic [7:0] lc);
        logic [NKW-1:0] r;
        r = kwc;
        for (int k = 0; k < NKW; k++) begin
            if (!pos_ok || KW_TEXT[k][63 - 8*pos -: 8] != lc)
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [5:0] ident_type(input logic [NKW-1:0] kwc,
                                              input logic [2:0] len,
                                              input logic len_ok);
        logic [5:0] t;
        logic       found;
        t = T_IDENT;
        found = 1'b0;
        for (int k = 0; k < NKW; k++) begin
            if (!found && len_ok && kwc[k] && KW_LEN[k] == len) begin
                t = KW_TYPE[k];
                found = 1'b1;
            end
        end
        return t;
    endfunction

    function automatic pst_rec_t mk_char(input logic [7:0] c, input logic [15:0] line);
        pst_rec_t r;
        r = '0;
        r.rec_kind = REC_CHAR;
        r.text_char = c;
        r.token_line = line;
        return r;
    endfunction

    function automatic pst_rec_t mk_end(input logic [5:0] t, input logic [1:0] err,
                                        input logic [15:0] line);
        pst_rec_t r;
        r = '0;
        r.rec_kind = REC_END;
        r.token_type = t;
        r.error_code = err;
        r.token_line = line;
        return r;
    endfunction

endpackage

/* src/pascal_subset_tokenizer_unit.sv */
// top level of the pascal subset tokenizer
// depends on pst_pkg, pst_lexer, pst_outbuf
//
// usage:
//   byte channel: one source character per request (byte_valid/byte_stall),
//     byte 0 or end_of_input ends the input and flushes the pending token
//   token channel: one record per request (tok_valid/tok_stall), text
//     character records followed by a token-end record, last marks the
//     final record caused by one source byte
//   latency: records of a byte appear the cycle after it is accepted
//   throughput: one byte per cycle while each byte gives at most one record and
//     tok_stall is low; a byte giving more records holds the byte channel until
//     its last record leaves, set by the single-record port of the result buffer
//   reset: lexer idle, line count 1, result buffer empty, no halt
//   stall on the token side: the head record holds, and the byte channel
//     stalls while any record is left in the buffer at the end of the cycle
//   after an unterminated string or unknown character the block accepts
//     bytes but gives no records until reset
module pascal_subset_tokenizer_unit #(
    parameter int MAX_TEXT_LEN = 32,
    parameter int LINE_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  pst_pkg::pst_in_t   byte_req,
    output logic               tok_valid,
    input  logic               tok_stall,
    output pst_pkg::pst_rec_t  tok_req
);
    import pst_pkg::*;

    pst_rec_t   recs [3];
    logic [1:0] nrec;
    logic       room;
    logic       accept;

    // a byte enters only when the buffer will be empty next cycle
    assign byte_stall = !room;
    assign accept = byte_valid && room;

    // lexer state and step logic
    pst_lexer #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN),
        .LINE_BITS    (LINE_BITS)
    ) u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (byte_req),
        .recs   (recs),
        .nrec   (nrec)
    );

    // result buffer toward the token channel
    pst_outbuf u_outbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .recs  (recs),
        .nrec  (nrec),
        .room  (room),
        .valid (tok_valid),
        .stall (tok_stall),
        .rec   (tok_req)
    );

endmodule

/* src/pst_lexer.sv */
// lexer state registers and the one-byte step logic
// depends on pst_pkg
module pst_lexer #(
    parameter int MAX_TEXT_LEN = 32,
    parameter int LINE_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  pst_pkg::pst_in_t   req,
    output pst_pkg::pst_rec_t  recs [3],
    output logic [1:0]         nrec
);
    import pst_pkg::*;

    localparam int TCW = $clog2(MAX_TEXT_LEN);
    localparam logic [TCW-1:0] TC_LIMIT = TCW'(MAX_TEXT_LEN - 1);
    localparam logic [TCW-1:0] TC_KW    = TCW'(8);

    pst_mode_t            mode_reg, mode_next;
    logic [TCW-1:0]       tc_reg, tc_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] sl_reg, sl_next;
    logic [NKW-1:0]       kwc_reg, kwc_next;
    logic                 halted_reg, halted_next;

    logic [7:0]  c, lc;
    logic        eoi, consumed, pos_ok;
    logic [15:0] old_line, cur_line;
    logic [LINE_BITS-1:0] line_inc;

    always_comb
    begin
        c = req.in_byte;
        lc = to_lower(c);
        eoi = req.end_of_input || c == 8'd0;
        pos_ok = tc_reg < TC_KW;
        old_line = 16'(sl_reg);
        cur_line = 16'(line_reg);
        line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;
        mode_next = mode_reg;
        tc_next = tc_reg;
        line_next = line_reg;
        sl_next = sl_reg;
        kwc_next = kwc_reg;
        halted_next = halted_reg;
        consumed = 1'b0;
        nrec = 2'd0;
        recs[0] = '0;
        recs[1] = '0;
        recs[2] = '0;
        if (!halted_reg)
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (!eoi && (is_alpha(c) || is_digit(c)))
                    begin
                        consumed = 1'b1;
                        if (tc_reg < TC_LIMIT)
                        begin
                            recs[nrec] = mk_char(c, old_line);
                            nrec = nrec + 2'd1;
                            tc_next = tc_reg + 1'b1;
                            kwc_next = kw_update(kwc_reg, tc_reg[2:0], pos_ok, lc);
                        end
                    end
                    else
                    begin
                        recs[nrec] = mk_end(ident_type(kwc_reg, tc_reg[2:0], pos_ok),
                                            ERR_NONE, old_line);
                        nrec = nrec + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_NUMBER:
                begin
                    if (!eoi && is_digit(c))
                    begin
                        consumed = 1'b1;
                        if (tc_reg < TC_LIMIT)
                        begin
                            recs[nrec] = mk_char(c, old_line);
                            nrec = nrec + 2'd1;
                            tc_next = tc_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        recs[nrec] = mk_end(T_INTLIT, ERR_NONE, old_line);
                        nrec = nrec + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_STRING:
                begin
                    consumed = 1'b1;
                    if (eoi || c == "\n")
                    begin
                        recs[nrec] = mk_end(T_STRLIT, ERR_STRING, old_line);
                        nrec = nrec + 2'd1;
                        halted_next = 1'b1;
                    end
                    else if (c == "'")
                    begin
                        recs[nrec] = mk_end(T_STRLIT, ERR_NONE, old_line);
                        nrec = nrec + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (tc_reg < TC_LIMIT)
                    begin
                        recs[nrec] = mk_char(c, old_line);
                        nrec = nrec + 2'd1;
                        tc_next = tc_reg + 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (eoi)
                        mode_next = M_IDLE;
                    else
                    begin
                        consumed = 1'b1;
                        if (c == "\n")
                            line_next = line_inc;
                        else if (c == "}")
                            mode_next = M_IDLE;
                    end
                end
                M_COLON, M_LESS, M_GREATER:
                begin
                    if (!eoi && c == "=")
                    begin
                        consumed = 1'b1;
                        recs[nrec] = mk_char(c, old_line);
                        nrec = nrec + 2'd1;
                        recs[nrec] = mk_end((mode_reg == M_COLON) ? T_ASSIGN :
                                            (mode_reg == M_LESS) ? T_LE : T_GE,
                                            ERR_NONE, old_line);
                        nrec = nrec + 2'd1;
                    end
                    else if (!eoi && c == ">" && mode_reg == M_LESS)
                    begin
                        consumed = 1'b1;
                        recs[nrec] = mk_char(c, old_line);
                        nrec = nrec + 2'd1;
                        recs[nrec] = mk_end(T_NE, ERR_NONE, old_line);
                        nrec = nrec + 2'd1;
                    end
                    else
                    begin
                        recs[nrec] = mk_end((mode_reg == M_COLON) ? T_COLON :
                                            (mode_reg == M_LESS) ? T_LT : T_GT,
                                            ERR_NONE, old_line);
                        nrec = nrec + 2'd1;
                    end
                    mode_next = M_IDLE;
                end
                default:
                    mode_next = M_IDLE;
            endcase

            if (eoi && !halted_next)
            begin
                sl_next = line_reg;
                tc_next = '0;
                kwc_next = '1;
                recs[nrec] = mk_end(T_END, ERR_NONE, cur_line);
                nrec = nrec + 2'd1;
                mode_next = M_IDLE;
            end
            else if (!consumed && !halted_next && !eoi)
            begin
                if (c == " " || c == "\t" || c == "\r")
                    mode_next = M_IDLE;
                else if (c == "\n")
                    line_next = line_inc;
                else if (c == "{")
                    mode_next = M_COMMENT;
                else
                begin
                    sl_next = line_reg;
                    tc_next = '0;
                    kwc_next = '1;
                    if (c == "'")
                        mode_next = M_STRING;
                    else
                    begin
                        recs[nrec] = mk_char(c, cur_line);
                        nrec = nrec + 2'd1;
                        if (is_alpha(c))
                        begin
                            mode_next = M_IDENT;
                            tc_next = TCW'(1);
                            kwc_next = kw_update('1, 3'd0, 1'b1, lc);
                        end
                        else if (is_digit(c))
                        begin
                            mode_next = M_NUMBER;
                            tc_next = TCW'(1);
                        end
                        else
                        begin
                            case (c)
                                ":": mode_next = M_COLON;
                                "<": mode_next = M_LESS;
                                ">": mode_next = M_GREATER;
                                "+": recs[nrec] = mk_end(T_PLUS, ERR_NONE, cur_line);
                                "-": recs[nrec] = mk_end(T_MINUS, ERR_NONE, cur_line);
                                "*": recs[nrec] = mk_end(T_STAR, ERR_NONE, cur_line);
                                "/": recs[nrec] = mk_end(T_SLASH, ERR_NONE, cur_line);
                                "=": recs[nrec] = mk_end(T_EQ, ERR_NONE, cur_line);
                                "(": recs[nrec] = mk_end(T_LPAREN, ERR_NONE, cur_line);
                                ")": recs[nrec] = mk_end(T_RPAREN, ERR_NONE, cur_line);
                                ";": recs[nrec] = mk_end(T_SEMI, ERR_NONE, cur_line);
                                ",": recs[nrec] = mk_end(T_COMMA, ERR_NONE, cur_line);
                                ".": recs[nrec] = mk_end(T_END, ERR_NONE, cur_line);
                                default:
                                begin
                                    recs[nrec] = mk_end(T_END, ERR_UNKNOWN, cur_line);
                                    halted_next = 1'b1;
                                end
                            endcase
                            if (c != ":" && c != "<" && c != ">")
                                nrec = nrec + 2'd1;
                        end
                    end
                end
            end
        end
        if (nrec != 2'd0)
            recs[nrec - 2'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            tc_reg <= '0;
            line_reg <= LINE_BITS'(1);
            sl_reg <= LINE_BITS'(1);
            kwc_reg <= '1;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            tc_reg <= tc_next;
            line_reg <= line_next;
            sl_reg <= sl_next;
            kwc_reg <= kwc_next;
            halted_reg <= halted_next;
        end
    end

endmodule

/* src/pst_outbuf.sv */
// three-entry result buffer that drains one record per cycle while not stalled
// depends on pst_pkg
module pst_outbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pst_pkg::pst_rec_t  recs [3],
    input  logic [1:0]         nrec,
    output logic               room,
    output logic               valid,
    input  logic               stall,
    output pst_pkg::pst_rec_t  rec
);
    import pst_pkg::*;

    pst_rec_t   q_reg [3];
    pst_rec_t   q_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign valid = cnt_reg != 2'd0;
    assign rec = q_reg[0];
    assign pop = valid && !stall;
    // free when empty or once the last held record leaves this cycle
    assign room = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && !stall);

    always_comb
    begin
        q_next = q_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            q_next = recs;
            cnt_next = nrec;
        end
        else if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule
